// ----- rtl/catmull_rom_table_eval_assert.svh -----
// Assertion macros for the spline evaluator; they expand to nothing in synthesis.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef CATMULL_ROM_TABLE_EVAL_ASSERT_SVH
`define CATMULL_ROM_TABLE_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define CRTE_ASSERT(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("crte: property failed");
`define CRTE_IMPLY(lbl, ante, cons) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) (ante) |-> (cons)) else $error("crte: implication failed");
`else
`define CRTE_ASSERT(lbl, prop)
`define CRTE_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- rtl/crte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package crte_pkg;

    localparam int VAL_W       = 32;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int MAX_NODES   = 64;
    localparam int DIFF_W      = VAL_W + 1;
    localparam int TAN_W       = 36;
    localparam int TAN_CAP_LOG = 34;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_LO, S_RD_HI, S_SRCH, S_F0, S_F1, S_FM, S_FP,
        S_TDIV, S_TWAIT, S_P0, S_D0S, S_D0W, S_P1, S_D1S, S_D1W,
        S_SQ, S_CU, S_WT, S_ACC, S_RND, S_DONE
    } state_t;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] node_position;
        logic signed [VAL_W-1:0] node_value;
        logic signed [VAL_W-1:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    in_range;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/catmull_rom_table_eval.sv -----
// Load beat: writes one table entry, no result. Query: out of range, answers after the
// two end reads with in_range low; in range, a binary search, 4 neighbor reads and up
// to three divisions (t and two tangents) come before the rounded result.
// One item at a time (s_ready only while idle); the bit-serial divider sets the query time.
// Reset (synchronous, aresetn low): control idles, node_count returns to 2,
// table contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_table_eval #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [crte_pkg::IDX_W-1:0]        s_entry_index,
    input  wire logic signed [crte_pkg::VAL_W-1:0] s_node_position,
    input  wire logic signed [crte_pkg::VAL_W-1:0] s_node_value,
    input  wire logic signed [crte_pkg::VAL_W-1:0] s_query_x,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [crte_pkg::VAL_W-1:0]      m_result_value,
    output logic                                   m_in_range,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crte_pkg::CNT_W-1:0]        cfg_data
);

    logic [crte_pkg::CNT_W-1:0] node_count_reg;
    logic                       m_valid_reg, m_valid_next;
    crte_pkg::res_t             m_res_reg;
    crte_pkg::req_t             req;
    crte_pkg::stat_t            stat;
    crte_pkg::res_t             res;
    logic                       res_ack;

    assign req.req_type      = s_req_type;
    assign req.entry_index   = s_entry_index;
    assign req.node_position = s_node_position;
    assign req.node_value    = s_node_value;
    assign req.query_x       = s_query_x;

    assign s_ready   = stat.idle;
    assign cfg_ready = 1'b1;

    crte_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid && s_ready),
        .req        (req),
        .node_count (node_count_reg),
        .res_ack    (res_ack),
        .stat       (stat),
        .res        (res)
    );

    // node count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= crte_pkg::CNT_W'(2);
        end else if (cfg_valid && cfg_ready) begin
            node_count_reg <= cfg_data;
        end
    end

    // take a finished result when the output register is free or draining
    assign res_ack = stat.done && (!m_valid_reg || m_ready);

    always_comb begin
        priority if (res_ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_res_reg.result_value;
    assign m_in_range     = m_res_reg.in_range;

endmodule
`default_nettype wire

// ----- rtl/crte_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/crte_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crte_div #(
    parameter int DW = 66,
    parameter int VW = 33
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [DW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          ge;

    // one restoring step: shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/crte_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "catmull_rom_table_eval_assert.svh"
module crte_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          req_valid,
    input  wire crte_pkg::req_t                req,
    input  wire logic [crte_pkg::CNT_W-1:0]    node_count,
    input  wire logic                          res_ack,
    output crte_pkg::stat_t                    stat,
    output crte_pkg::res_t                     res
);

    localparam int MAX_NODES = crte_pkg::MAX_NODES;
    localparam int VAL_W  = crte_pkg::VAL_W;
    localparam int DIFF_W = crte_pkg::DIFF_W;
    localparam int TAN_W  = crte_pkg::TAN_W;
    localparam int IW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int NW1    = NW + 1;
    localparam int TW     = FRAC_BITS + 1;
    localparam int HW     = FRAC_BITS + 4;
    localparam int PW     = TAN_W + HW;
    localparam int AW     = PW + 2;
    localparam int MW     = 2 * DIFF_W;
    localparam int DW     = (MW > DIFF_W + FRAC_BITS) ? MW : DIFF_W + FRAC_BITS;
    localparam int RW     = 2 * VAL_W;

    localparam logic [TW-1:0]        ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [HW-1:0] ONE_H = {{(HW - TW){1'b0}}, ONE};
    localparam logic [DW-1:0]        TCAP  = DW'(1) << crte_pkg::TAN_CAP_LOG;
    localparam logic signed [AW-1:0] HALF  =
        {{(AW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [TAN_W-1:0] tan_fin(input logic [DW-1:0] q,
                                                        input logic neg);
        logic [TAN_W-1:0] m;
        m = (q > TCAP) ? TAN_W'(TCAP) : TAN_W'(q);
        return neg ? -m : m;
    endfunction

    crte_pkg::state_t state_reg, state_next;

    // table read/write port
    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [RW-1:0]     ram_wdata, ram_rdata;
    logic signed [VAL_W-1:0] rd_pos, rd_val;

    // query context
    logic signed [VAL_W-1:0] x_reg, lo_reg;
    logic [NW-1:0]           n_reg, first_reg, len_reg;
    logic [IW-1:0]           idx_reg;
    logic signed [VAL_W-1:0] x0_reg, x1_reg, xm_reg, xp_reg;
    logic signed [VAL_W-1:0] f0_reg, f1_reg, fm_reg, fp_reg;
    logic [TW-1:0]           t_reg, t2_reg;
    logic signed [TAN_W-1:0] d0_reg, d1_reg;
    logic [MW-1:0]           prod_a_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [HW-1:0]    h00_reg, h01_reg, h10_reg, h11_reg;
    logic signed [AW-1:0]    acc_reg;
    logic [2:0]              term_reg;
    logic signed [VAL_W-1:0] res_value_reg;
    logic                    in_range_reg;

    // combinational helpers
    logic [NW-1:0]           n_clamp, half, mid, first_new, len_new, mid_new, idx_c, idx_raw;
    logic                    pos_le, in_rng;
    logic signed [DIFF_W-1:0] w, xd, fd, diff0, den0, diff1, den1;
    logic                    d0_used, d1_used, t_ok, tan0_ok, tan1_ok, neg0, neg1;
    logic [DW-1:0]           tdiv_dd, div_dd, div_q;
    logic [DIFF_W-1:0]       div_dsr;
    logic                    div_start, div_busy, div_done;
    logic [MW-1:0]           mul_a_c;
    logic signed [TAN_W-1:0] mul_a;
    logic signed [HW-1:0]    mul_b;
    logic signed [PW-1:0]    prod_c;
    logic [TW-1:0]           t_q, t3_c;
    logic signed [HW-1:0]    te, t2e, t3e;
    logic signed [AW-1:0]    rnd_sh;
    logic signed [VAL_W-1:0] rnd_sat;

    crte_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crte_div #(.DW(DW), .VW(DIFF_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_pos = ram_rdata[RW-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    // clamp the node count to between 2 and the table size
    always_comb begin
        if (node_count < 2) begin
            n_clamp = NW'(2);
        end else if (32'(node_count) > 32'(MAX_NODES)) begin
            n_clamp = NW'(MAX_NODES);
        end else begin
            n_clamp = NW'(node_count);
        end
    end

    // one binary search step on the node just read
    always_comb begin
        half   = len_reg >> 1;
        mid    = first_reg + half;
        pos_le = rd_pos <= x_reg;
        if (pos_le) begin
            first_new = mid + 1'b1;
            len_new   = len_reg - half - 1'b1;
        end else begin
            first_new = first_reg;
            len_new   = half;
        end
        mid_new = first_new + (len_new >> 1);
        idx_raw = (first_new == '0) ? '0 : first_new - 1'b1;
        idx_c   = (idx_raw > n_reg - NW'(2)) ? n_reg - NW'(2) : idx_raw;
    end

    assign in_rng = (x_reg >= lo_reg) && (x_reg <= rd_pos);

    // interval differences
    assign w     = {x1_reg[VAL_W-1], x1_reg} - {x0_reg[VAL_W-1], x0_reg};
    assign xd    = {x_reg[VAL_W-1], x_reg} - {x0_reg[VAL_W-1], x0_reg};
    assign fd    = {f1_reg[VAL_W-1], f1_reg} - {f0_reg[VAL_W-1], f0_reg};
    assign diff0 = {f1_reg[VAL_W-1], f1_reg} - {fm_reg[VAL_W-1], fm_reg};
    assign den0  = {x1_reg[VAL_W-1], x1_reg} - {xm_reg[VAL_W-1], xm_reg};
    assign diff1 = {fp_reg[VAL_W-1], fp_reg} - {f0_reg[VAL_W-1], f0_reg};
    assign den1  = {xp_reg[VAL_W-1], xp_reg} - {x0_reg[VAL_W-1], x0_reg};

    assign d0_used = idx_reg != '0;
    assign d1_used = (NW1'(idx_reg) + NW1'(2)) < NW1'(n_reg);
    assign t_ok    = (w != '0) && (xd[DIFF_W-1] == w[DIFF_W-1]);
    assign tan0_ok = d0_used && (den0 != '0) && (w != '0) && (diff0 != '0);
    assign tan1_ok = d1_used && (den1 != '0) && (w != '0) && (diff1 != '0);
    assign neg0    = w[DIFF_W-1] ^ diff0[DIFF_W-1] ^ den0[DIFF_W-1];
    assign neg1    = w[DIFF_W-1] ^ diff1[DIFF_W-1] ^ den1[DIFF_W-1];

    // divider operands
    assign tdiv_dd = DW'(mag(xd)) << FRAC_BITS;
    assign div_dd  = (state_reg == crte_pkg::S_TDIV) ? tdiv_dd : DW'(prod_a_reg);
    always_comb begin
        priority if (state_reg == crte_pkg::S_TDIV) begin
            div_dsr = mag(w);
        end else if (state_reg == crte_pkg::S_D0S) begin
            div_dsr = mag(den0);
        end else begin
            div_dsr = mag(den1);
        end
    end
    assign t_q = (div_q > DW'(ONE)) ? ONE : div_q[TW-1:0];

    // tangent numerator product
    assign mul_a_c = mag(w) * ((state_reg == crte_pkg::S_P1) ? mag(diff1) : mag(diff0));

    // shared signed multiplier for powers of t and the Hermite terms
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            crte_pkg::S_SQ: begin
                mul_a = {{(TAN_W - TW){1'b0}}, t_reg};
                mul_b = {{(HW - TW){1'b0}}, t_reg};
            end
            crte_pkg::S_CU: begin
                mul_a = {{(TAN_W - TW){1'b0}}, prod_reg[2*FRAC_BITS:FRAC_BITS]};
                mul_b = {{(HW - TW){1'b0}}, t_reg};
            end
            crte_pkg::S_ACC: begin
                unique case (term_reg)
                    3'd0: begin
                        mul_a = {{(TAN_W - VAL_W){f0_reg[VAL_W-1]}}, f0_reg};
                        mul_b = h00_reg;
                    end
                    3'd1: begin
                        mul_a = {{(TAN_W - VAL_W){f1_reg[VAL_W-1]}}, f1_reg};
                        mul_b = h01_reg;
                    end
                    3'd2: begin
                        mul_a = d0_reg;
                        mul_b = h10_reg;
                    end
                    3'd3: begin
                        mul_a = d1_reg;
                        mul_b = h11_reg;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod_c = mul_a * mul_b;

    // weight inputs
    assign t3_c = prod_reg[2*FRAC_BITS:FRAC_BITS];
    assign te   = {{(HW - TW){1'b0}}, t_reg};
    assign t2e  = {{(HW - TW){1'b0}}, t2_reg};
    assign t3e  = {{(HW - TW){1'b0}}, t3_c};

    // round half up, drop the fraction, saturate
    assign rnd_sh = (acc_reg + HALF) >>> FRAC_BITS;
    always_comb begin
        if ((&rnd_sh[AW-1:VAL_W-1]) || (~|rnd_sh[AW-1:VAL_W-1])) begin
            rnd_sat = rnd_sh[VAL_W-1:0];
        end else if (rnd_sh[AW-1]) begin
            rnd_sat = {1'b1, {(VAL_W - 1){1'b0}}};
        end else begin
            rnd_sat = {1'b0, {(VAL_W - 1){1'b1}}};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crte_pkg::S_IDLE: begin
                if (req_valid && req.req_type == crte_pkg::REQ_QUERY) begin
                    state_next = crte_pkg::S_RD_LO;
                end
            end
            crte_pkg::S_RD_LO: state_next = crte_pkg::S_RD_HI;
            crte_pkg::S_RD_HI: state_next = in_rng ? crte_pkg::S_SRCH : crte_pkg::S_DONE;
            crte_pkg::S_SRCH: begin
                if (len_new == '0) begin
                    state_next = crte_pkg::S_F0;
                end
            end
            crte_pkg::S_F0:    state_next = crte_pkg::S_F1;
            crte_pkg::S_F1:    state_next = crte_pkg::S_FM;
            crte_pkg::S_FM:    state_next = crte_pkg::S_FP;
            crte_pkg::S_FP:    state_next = crte_pkg::S_TDIV;
            crte_pkg::S_TDIV:  state_next = t_ok ? crte_pkg::S_TWAIT : crte_pkg::S_P0;
            crte_pkg::S_TWAIT: state_next = div_done ? crte_pkg::S_P0 : crte_pkg::S_TWAIT;
            crte_pkg::S_P0:    state_next = tan0_ok ? crte_pkg::S_D0S : crte_pkg::S_P1;
            crte_pkg::S_D0S:   state_next = crte_pkg::S_D0W;
            crte_pkg::S_D0W:   state_next = div_done ? crte_pkg::S_P1 : crte_pkg::S_D0W;
            crte_pkg::S_P1:    state_next = tan1_ok ? crte_pkg::S_D1S : crte_pkg::S_SQ;
            crte_pkg::S_D1S:   state_next = crte_pkg::S_D1W;
            crte_pkg::S_D1W:   state_next = div_done ? crte_pkg::S_SQ : crte_pkg::S_D1W;
            crte_pkg::S_SQ:    state_next = crte_pkg::S_CU;
            crte_pkg::S_CU:    state_next = crte_pkg::S_WT;
            crte_pkg::S_WT:    state_next = crte_pkg::S_ACC;
            crte_pkg::S_ACC: begin
                if (term_reg == 3'd4) begin
                    state_next = crte_pkg::S_RND;
                end
            end
            crte_pkg::S_RND:   state_next = crte_pkg::S_DONE;
            crte_pkg::S_DONE: begin
                if (res_ack) begin
                    state_next = crte_pkg::S_IDLE;
                end
            end
            default:           state_next = crte_pkg::S_IDLE;
        endcase
    end

    // table port and divider start
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = IW'(req.entry_index);
        ram_wdata = {req.node_position, req.node_value};
        ram_re    = 1'b0;
        ram_raddr = '0;
        div_start = 1'b0;
        unique case (state_reg)
            crte_pkg::S_IDLE: begin
                if (req_valid && req.req_type == crte_pkg::REQ_LOAD) begin
                    ram_we = 32'(req.entry_index) < 32'(MAX_NODES);
                end
                if (req_valid && req.req_type == crte_pkg::REQ_QUERY) begin
                    ram_re = 1'b1;
                end
            end
            crte_pkg::S_RD_LO: begin
                ram_re    = 1'b1;
                ram_raddr = IW'(n_reg - 1'b1);
            end
            crte_pkg::S_RD_HI: begin
                ram_re    = 1'b1;
                ram_raddr = IW'(n_reg >> 1);
            end
            crte_pkg::S_SRCH: begin
                ram_re    = 1'b1;
                ram_raddr = (len_new != '0) ? IW'(mid_new) : IW'(idx_c);
            end
            crte_pkg::S_F0: begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg + 1'b1;
            end
            crte_pkg::S_F1: begin
                ram_re    = 1'b1;
                ram_raddr = d0_used ? idx_reg - 1'b1 : idx_reg;
            end
            crte_pkg::S_FM: begin
                ram_re    = 1'b1;
                ram_raddr = d1_used ? idx_reg + IW'(2) : idx_reg + 1'b1;
            end
            crte_pkg::S_TDIV: div_start = t_ok;
            crte_pkg::S_D0S:  div_start = 1'b1;
            crte_pkg::S_D1S:  div_start = 1'b1;
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crte_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            crte_pkg::S_IDLE: begin
                x_reg <= req.query_x;
                n_reg <= n_clamp;
            end
            crte_pkg::S_RD_LO: lo_reg <= rd_pos;
            crte_pkg::S_RD_HI: begin
                first_reg     <= '0;
                len_reg       <= n_reg;
                res_value_reg <= '0;
                in_range_reg  <= 1'b0;
            end
            crte_pkg::S_SRCH: begin
                first_reg <= first_new;
                len_reg   <= len_new;
                idx_reg   <= IW'(idx_c);
            end
            crte_pkg::S_F0: begin
                x0_reg <= rd_pos;
                f0_reg <= rd_val;
            end
            crte_pkg::S_F1: begin
                x1_reg <= rd_pos;
                f1_reg <= rd_val;
            end
            crte_pkg::S_FM: begin
                xm_reg <= rd_pos;
                fm_reg <= rd_val;
            end
            crte_pkg::S_FP: begin
                xp_reg <= rd_pos;
                fp_reg <= rd_val;
            end
            crte_pkg::S_TDIV: t_reg <= '0;
            crte_pkg::S_TWAIT: begin
                if (div_done) begin
                    t_reg <= t_q;
                end
            end
            crte_pkg::S_P0: begin
                prod_a_reg <= mul_a_c;
                d0_reg     <= d0_used ? '0 : {{(TAN_W - DIFF_W){fd[DIFF_W-1]}}, fd};
            end
            crte_pkg::S_D0W: begin
                if (div_done) begin
                    d0_reg <= tan_fin(div_q, neg0);
                end
            end
            crte_pkg::S_P1: begin
                prod_a_reg <= mul_a_c;
                d1_reg     <= d1_used ? '0 : {{(TAN_W - DIFF_W){fd[DIFF_W-1]}}, fd};
            end
            crte_pkg::S_D1W: begin
                if (div_done) begin
                    d1_reg <= tan_fin(div_q, neg1);
                end
            end
            crte_pkg::S_SQ: prod_reg <= prod_c;
            crte_pkg::S_CU: begin
                t2_reg   <= prod_reg[2*FRAC_BITS:FRAC_BITS];
                prod_reg <= prod_c;
            end
            crte_pkg::S_WT: begin
                h00_reg  <= (t3e <<< 1) - (t2e + (t2e <<< 1)) + ONE_H;
                h01_reg  <= (t2e + (t2e <<< 1)) - (t3e <<< 1);
                h10_reg  <= t3e - (t2e <<< 1) + te;
                h11_reg  <= t3e - t2e;
                acc_reg  <= '0;
                term_reg <= '0;
            end
            crte_pkg::S_ACC: begin
                prod_reg <= prod_c;
                term_reg <= term_reg + 1'b1;
                if (term_reg != 3'd0) begin
                    acc_reg <= acc_reg + {{2{prod_reg[PW-1]}}, prod_reg};
                end
            end
            crte_pkg::S_RND: begin
                res_value_reg <= rnd_sat;
                in_range_reg  <= 1'b1;
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    assign stat.idle        = state_reg == crte_pkg::S_IDLE;
    assign stat.done        = state_reg == crte_pkg::S_DONE;
    assign res.result_value = res_value_reg;
    assign res.in_range     = in_range_reg;

    `CRTE_IMPLY(a_srch_bound, state_reg == crte_pkg::S_SRCH, NW1'(first_reg) + NW1'(len_reg) <= NW1'(n_reg))
    `CRTE_IMPLY(a_idx_bound, state_reg == crte_pkg::S_SQ, NW1'(idx_reg) + NW1'(2) <= NW1'(n_reg))
    `CRTE_IMPLY(a_t_le_one, state_reg == crte_pkg::S_SQ, t_reg <= ONE)
    `CRTE_IMPLY(a_div_free, div_start, !div_busy)
    `CRTE_ASSERT(a_wait_div, (state_reg == crte_pkg::S_TWAIT) |-> (div_busy || div_done))

endmodule
`default_nettype wire
